@@ design/utf16_to_utf8_transcoder_defines.svh @@
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder assertion macros
// Property macros for the blocks' checks. They are empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef UTF16_TO_UTF8_TRANSCODER_DEFINES_SVH
`define UTF16_TO_UTF8_TRANSCODER_DEFINES_SVH

`ifndef SYNTHESIS
`define U2U8_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed in same cycle");
`define U2U8_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed in next cycle");
`else
`define U2U8_ASSERT_SAME(label, clk, rst, ante, cons)
`define U2U8_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ design/u2u8_pkg.sv @@
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder package
// Shared constants, job types and the code point encoder.
// ----------------------------------------------------------------------------
package u2u8_pkg;

   localparam int QDepth = 4;
   localparam int QPtrW  = $clog2(QDepth);
   localparam int QCntW  = $clog2(QDepth + 1);

   localparam logic [5:0]  HighTag    = 6'b110110;
   localparam logic [5:0]  LowTag     = 6'b110111;
   localparam logic [20:0] SuppBase   = 21'h10000;
   localparam logic [20:0] Max1Byte   = 21'h7F;
   localparam logic [20:0] Max2Byte   = 21'h7FF;
   localparam logic [20:0] Max3Byte   = 21'hFFFF;
   localparam logic [7:0]  Lead2      = 8'hC0;
   localparam logic [7:0]  Lead3      = 8'hE0;
   localparam logic [7:0]  Lead4      = 8'hF0;
   localparam logic [7:0]  ContMark   = 8'h80;
   localparam logic [7:0]  ReplByte0  = 8'hEF;
   localparam logic [7:0]  ReplByte1  = 8'hBF;
   localparam logic [7:0]  ReplByte2  = 8'hBD;

   typedef struct packed {
      logic [3:0][7:0] octets;
      logic [2:0]      count;
   } enc_type;

   typedef struct packed {
      logic [5:0][7:0] octets;
      logic [2:0]      count;
   } job_type;

   function automatic enc_type encode_point(input logic [20:0] cp);
      enc_type e;
      e.octets = '0;
      if (cp <= Max1Byte) begin
         e.octets[0] = cp[7:0];
         e.count     = 3'd1;
      end else if (cp <= Max2Byte) begin
         e.octets[0] = Lead2 | {3'b000, cp[10:6]};
         e.octets[1] = ContMark | {2'b00, cp[5:0]};
         e.count     = 3'd2;
      end else if (cp <= Max3Byte) begin
         e.octets[0] = Lead3 | {4'b0000, cp[15:12]};
         e.octets[1] = ContMark | {2'b00, cp[11:6]};
         e.octets[2] = ContMark | {2'b00, cp[5:0]};
         e.count     = 3'd3;
      end else begin
         e.octets[0] = Lead4 | {5'b00000, cp[20:18]};
         e.octets[1] = ContMark | {2'b00, cp[17:12]};
         e.octets[2] = ContMark | {2'b00, cp[11:6]};
         e.octets[3] = ContMark | {2'b00, cp[5:0]};
         e.count     = 3'd4;
      end
      return e;
   endfunction

endpackage

@@ design/u2u8_req_if.sv @@
// ----------------------------------------------------------------------------
// Code unit channel
// Valid/ready channel that carries one UTF-16 code unit per transfer.
// ----------------------------------------------------------------------------
interface u2u8_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] code_unit;

   modport source (output valid, output code_unit, input ready);
   modport sink (input valid, input code_unit, output ready);
endinterface

@@ design/u2u8_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Byte channel
// Valid/ready channel that carries one UTF-8 byte and its last marker.
// ----------------------------------------------------------------------------
interface u2u8_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_out;
   logic       last_byte;

   modport source (output valid, output byte_out, output last_byte, input ready);
   modport sink (input valid, input byte_out, input last_byte, output ready);
endinterface

@@ design/u2u8_front.sv @@
// ----------------------------------------------------------------------------
// Transcoder front end
// Accepts code units, tracks a held high surrogate and builds byte jobs.
// ----------------------------------------------------------------------------
`include "utf16_to_utf8_transcoder_defines.svh"

module u2u8_front (
   input  logic              clock,
   input  logic              reset,
   u2u8_req_if.sink          req_chan,
   input  logic              full,
   output logic              push,
   output u2u8_pkg::job_type push_job
);
   import u2u8_pkg::*;

   logic        high_pending_ff;
   logic        high_pending_in;
   logic [9:0]  high_bits_ff;
   logic [9:0]  high_bits_in;
   logic        accept;
   logic        is_high;
   logic        is_low;
   logic [15:0] unit;
   enc_type     pair_enc;
   enc_type     unit_enc;
   enc_type     tail_enc;
   job_type     job;

   assign unit    = req_chan.code_unit;
   assign is_high = (unit[15:10] == HighTag);
   assign is_low  = (unit[15:10] == LowTag);
   assign accept  = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !full;

   assign pair_enc = encode_point(SuppBase + {1'b0, high_bits_ff, unit[9:0]});
   assign unit_enc = encode_point({5'b00000, unit});

   always_comb begin
      tail_enc = '0;
      if (unit == 16'h0000 || is_high) begin
         tail_enc = '0;
      end else if (is_low) begin
         tail_enc.octets[0] = ReplByte0;
         tail_enc.octets[1] = ReplByte1;
         tail_enc.octets[2] = ReplByte2;
         tail_enc.count     = 3'd3;
      end else begin
         tail_enc = unit_enc;
      end
   end

   always_comb begin
      job = '0;
      if (high_pending_ff && is_low) begin
         job.octets[3:0] = pair_enc.octets;
         job.count       = pair_enc.count;
      end else if (high_pending_ff) begin
         job.octets[0]   = ReplByte0;
         job.octets[1]   = ReplByte1;
         job.octets[2]   = ReplByte2;
         job.octets[5:3] = tail_enc.octets[2:0];
         job.count       = 3'd3 + tail_enc.count;
      end else begin
         job.octets[3:0] = tail_enc.octets;
         job.count       = tail_enc.count;
      end
   end

   assign push     = accept && (job.count != 3'd0);
   assign push_job = job;

   always_comb begin
      high_pending_in = high_pending_ff;
      high_bits_in    = high_bits_ff;
      if (accept) begin
         if (is_high && !(high_pending_ff && is_low)) begin
            high_pending_in = 1'b1;
            high_bits_in    = unit[9:0];
         end else begin
            high_pending_in = 1'b0;
            high_bits_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         high_pending_ff <= 1'b0;
         high_bits_ff    <= '0;
      end else begin
         high_pending_ff <= high_pending_in;
         high_bits_ff    <= high_bits_in;
      end
   end

   `U2U8_ASSERT_NEXT(a_high_held, clock, reset, accept && is_high, high_pending_ff)
   `U2U8_ASSERT_NEXT(a_zero_clears, clock, reset, accept && unit == 16'h0000, !high_pending_ff)
   `U2U8_ASSERT_SAME(a_pair_four, clock, reset, accept && high_pending_ff && is_low, push && job.count == 3'd4)

endmodule

@@ design/u2u8_queue.sv @@
// ----------------------------------------------------------------------------
// Transcoder job queue
// Short first-in first-out buffer of byte jobs between front and back end.
// ----------------------------------------------------------------------------
`include "utf16_to_utf8_transcoder_defines.svh"

module u2u8_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  u2u8_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output u2u8_pkg::job_type head
);
   import u2u8_pkg::*;

   job_type          store [QDepth];
   logic [QPtrW-1:0] wr_ptr_ff;
   logic [QPtrW-1:0] wr_ptr_in;
   logic [QPtrW-1:0] rd_ptr_ff;
   logic [QPtrW-1:0] rd_ptr_in;
   logic [QCntW-1:0] count_ff;
   logic [QCntW-1:0] count_in;

   assign full  = (count_ff == QCntW'(QDepth));
   assign empty = (count_ff == '0);
   assign head  = store[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `U2U8_ASSERT_SAME(a_no_overflow, clock, reset, push, !full)
   `U2U8_ASSERT_SAME(a_no_underflow, clock, reset, pop, !empty)
   `U2U8_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= QCntW'(QDepth))

endmodule

@@ design/u2u8_back.sv @@
// ----------------------------------------------------------------------------
// Transcoder back end
// Sends the bytes of the head job one per transfer through an output register.
// ----------------------------------------------------------------------------
module u2u8_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              empty,
   input  u2u8_pkg::job_type head,
   output logic              pop,
   u2u8_rsp_if.source        rsp_chan
);
   import u2u8_pkg::*;

   logic [2:0] idx_ff;
   logic [2:0] idx_in;
   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic       last_ff;
   logic       out_load;
   logic       emit;
   logic       is_last;

   assign out_load = !valid_ff || rsp_chan.ready;
   assign emit     = !empty && out_load;
   assign is_last  = (idx_ff == head.count - 3'd1);
   assign pop      = emit && is_last;

   always_comb begin
      idx_in = idx_ff;
      if (pop) begin
         idx_in = '0;
      end else if (emit) begin
         idx_in = idx_ff + 3'd1;
      end
      valid_in = valid_ff;
      if (out_load) begin
         valid_in = emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         byte_ff <= head.octets[idx_ff];
         last_ff <= is_last;
      end
   end

   assign rsp_chan.valid     = valid_ff;
   assign rsp_chan.byte_out  = byte_ff;
   assign rsp_chan.last_byte = last_ff;

endmodule

@@ design/utf16_to_utf8_transcoder.sv @@
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder
// Takes one UTF-16 code unit per transfer on req_chan and sends the UTF-8
// bytes it completes, one byte per transfer, on rsp_chan. The last byte
// caused by a code unit has last_byte set. A high surrogate is held until
// the next unit; an unpaired surrogate becomes U+FFFD. A zero code unit ends
// the text and sends nothing for itself.
// The first byte of a unit passes through the job queue and then the output
// register before it is offered. The output sends one byte per cycle while
// the receiver is ready and a job waits. A unit yields one to three bytes, a
// surrogate pair four, and a broken pair up to six. Units are taken every cycle
// while the four-entry job queue has room.
// Reset clears the held surrogate, the queue and the output register.
// When the receiver stalls, the output byte holds and the queue fills; the
// input then stops taking units until space frees up.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder (
   input  logic       clock,
   input  logic       reset,
   u2u8_req_if.sink   req_chan,
   u2u8_rsp_if.source rsp_chan
);
   import u2u8_pkg::*;

   logic    push;
   logic    pop;
   logic    full;
   logic    empty;
   job_type push_job;
   job_type head;

   u2u8_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .full     (full),
      .push     (push),
      .push_job (push_job)
   );

   u2u8_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (full),
      .pop      (pop),
      .empty    (empty),
      .head     (head)
   );

   u2u8_back u_back (
      .clock    (clock),
      .reset    (reset),
      .empty    (empty),
      .head     (head),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule
